// File: sv/petri_net_firing_engine_defines.svh
// assertion macros for the firing engine, used by the controller module
// a use of either macro sits on a line of its own and needs no semicolon
`ifndef PETRI_NET_FIRING_ENGINE_DEFINES_SVH
`define PETRI_NET_FIRING_ENGINE_DEFINES_SVH
`ifndef SYNTH
// property checked on every clock, off during reset
`define PNFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// antecedent this cycle implies consequent next cycle
`define PNFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PNFE_ASSERT(lbl, prop, msg)
`define PNFE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/pnfe_pkg.sv
`timescale 1ns / 1ps
package pnfe_pkg;

  // defaults of the top level parameters
  localparam int PlaceCountMaxDef = 16;
  localparam int ArcCountMaxDef   = 64;
  localparam int TokenBitsDef     = 16;
  // transitions scanned at most in one step
  localparam int TransCountMax    = 16;

  // field widths
  localparam int ActionW   = 3;
  localparam int SlotW     = 6;
  localparam int PlaceIdW  = 4;
  localparam int TransIdW  = 4;
  localparam int AmountW   = 16;
  localparam int PlacesW   = 5;
  localparam int TransUseW = 5;
  localparam int ArcsW     = 7;
  // width used for limit compares, holds any count up to 2047
  localparam int LimW      = 11;
  localparam int ApbAddrW  = 4;
  localparam int ApbDataW  = 32;

  typedef enum logic [ActionW-1:0] {
    ACT_WR_MARK    = 3'd0,
    ACT_WR_IN_ARC  = 3'd1,
    ACT_WR_OUT_ARC = 3'd2,
    ACT_STEP       = 3'd3,
    ACT_RD_MARK    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    REG_PLACES    = 2'd0,
    REG_TRANS     = 2'd1,
    REG_IN_ARCS   = 2'd2,
    REG_OUT_ARCS  = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    PASS_EN  = 2'd0,
    PASS_SUB = 2'd1,
    PASS_ADD = 2'd2
  } pass_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_WAIT,
    ST_PRIME,
    ST_ARC_P,
    ST_ARC_W,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [PlaceIdW-1:0] place;
    logic [TransIdW-1:0] transition;
    logic [AmountW-1:0]  weight;
  } arc_t;

  typedef struct packed {
    logic [PlacesW-1:0]   places;
    logic [TransUseW-1:0] transitions;
    logic [ArcsW-1:0]     in_arcs;
    logic [ArcsW-1:0]     out_arcs;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  mark_wr;
    logic  arc_in_wr;
    logic  arc_out_wr;
    logic  place_rd;
    logic  tok_cap;
    logic  step_init;
    logic  arc_prime;
    logic  arc_fetch;
    logic  arc_exec;
    logic  scan_next;
    logic  fire_hit;
    logic  res_load;
    pass_e pass;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    pass_empty;
    logic    arc_last;
    logic    scan_end;
    logic    scan_hit;
    logic    out_free;
  } sts_t;

endpackage

// File: sv/pnfe_ram.sv
`timescale 1ns / 1ps
module pnfe_ram
  import pnfe_pkg::*;
#(
  parameter int WIDTH  = $bits(arc_t),
  parameter int DEPTH  = ArcCountMaxDef,
  parameter int ADDR_W = SlotW
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/pnfe_cfg.sv
`timescale 1ns / 1ps
module pnfe_cfg
  import pnfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr;

  assign sel = reg_e'(paddr[3:2]);
  assign wr  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (sel)
        REG_PLACES:   cfg_d.places      = pwdata[PlacesW-1:0];
        REG_TRANS:    cfg_d.transitions = pwdata[TransUseW-1:0];
        REG_IN_ARCS:  cfg_d.in_arcs     = pwdata[ArcsW-1:0];
        REG_OUT_ARCS: cfg_d.out_arcs    = pwdata[ArcsW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_PLACES:   prdata = ApbDataW'(cfg_q.places);
      REG_TRANS:    prdata = ApbDataW'(cfg_q.transitions);
      REG_IN_ARCS:  prdata = ApbDataW'(cfg_q.in_arcs);
      REG_OUT_ARCS: prdata = ApbDataW'(cfg_q.out_arcs);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/pnfe_ctrl.sv
`timescale 1ns / 1ps
`include "petri_net_firing_engine_defines.svh"
module pnfe_ctrl
  import pnfe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  pass_e  pass_q, pass_d;

  // next state
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.action)
          ACT_RD_MARK: state_d = ST_RD_WAIT;
          ACT_STEP: begin
            state_d = ST_PRIME;
            pass_d  = PASS_EN;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_RD_WAIT: state_d = ST_DONE;
      ST_PRIME, ST_ARC_W: begin
        if ((state_q == ST_PRIME && sts_i.pass_empty) ||
            (state_q == ST_ARC_W && sts_i.arc_last)) begin
          unique case (pass_q)
            PASS_EN: state_d = ST_SCAN;
            PASS_SUB: begin
              state_d = ST_PRIME;
              pass_d  = PASS_ADD;
            end
            default: state_d = ST_DONE;
          endcase
        end else begin
          state_d = ST_ARC_P;
        end
      end
      ST_ARC_P: state_d = ST_ARC_W;
      ST_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = ST_DONE;
        end else if (sts_i.scan_hit) begin
          state_d = ST_PRIME;
          pass_d  = PASS_SUB;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.pass = pass_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DECODE: begin
        unique case (sts_i.action)
          ACT_WR_MARK:    cmd_o.mark_wr    = 1'b1;
          ACT_WR_IN_ARC:  cmd_o.arc_in_wr  = 1'b1;
          ACT_WR_OUT_ARC: cmd_o.arc_out_wr = 1'b1;
          ACT_STEP:       cmd_o.step_init  = 1'b1;
          ACT_RD_MARK:    cmd_o.place_rd   = 1'b1;
          default:        cmd_o.load       = 1'b0;
        endcase
      end
      ST_RD_WAIT: cmd_o.tok_cap   = 1'b1;
      ST_PRIME:   cmd_o.arc_prime = 1'b1;
      ST_ARC_P:   cmd_o.arc_fetch = 1'b1;
      ST_ARC_W:   cmd_o.arc_exec  = 1'b1;
      ST_SCAN: begin
        cmd_o.fire_hit  = !sts_i.scan_end && sts_i.scan_hit;
        cmd_o.scan_next = !sts_i.scan_end && !sts_i.scan_hit;
      end
      ST_DONE:    cmd_o.res_load  = sts_i.out_free;
      default:    cmd_o.load      = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= PASS_EN;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  `PNFE_ASSERT_NEXT(a_accept_decode, state_q == ST_IDLE && in_valid_i, state_q == ST_DECODE, "request accepted but not decoded")
  `PNFE_ASSERT(a_cmd_excl, $onehot0({cmd_o.mark_wr, cmd_o.arc_in_wr, cmd_o.arc_out_wr, cmd_o.arc_exec}), "conflicting datapath commands")
  `PNFE_ASSERT_NEXT(a_hit_fires, state_q == ST_SCAN && !sts_i.scan_end && sts_i.scan_hit, state_q == ST_PRIME && pass_q == PASS_SUB, "enabled transition not fired")
  `PNFE_ASSERT_NEXT(a_done_holds, state_q == ST_DONE && !sts_i.out_free, state_q == ST_DONE, "result dropped while output busy")

endmodule

// File: sv/pnfe_dp.sv
`timescale 1ns / 1ps
module pnfe_dp
  import pnfe_pkg::*;
#(
  parameter int PLACE_COUNT_MAX = PlaceCountMaxDef,
  parameter int ARC_COUNT_MAX   = ArcCountMaxDef,
  parameter int TOKEN_BITS      = TokenBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [ActionW-1:0]  action_i,
  input  logic [SlotW-1:0]    slot_i,
  input  logic [PlaceIdW-1:0] place_id_i,
  input  logic [TransIdW-1:0] transition_id_i,
  input  logic [AmountW-1:0]  amount_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                fired_o,
  output logic [TransIdW-1:0] fired_transition_o,
  output logic [AmountW-1:0]  token_count_o
);

  localparam int PlaceDepth = (PLACE_COUNT_MAX < 2**PlaceIdW) ? PLACE_COUNT_MAX : 2**PlaceIdW;
  localparam int PaW        = $clog2(PlaceDepth);
  localparam int ArcDepth   = (ARC_COUNT_MAX < 2**SlotW) ? ARC_COUNT_MAX : 2**SlotW;
  localparam int AaW        = (ArcDepth > 1) ? $clog2(ArcDepth) : 1;
  localparam int IdxW       = $clog2(ArcDepth + 1);
  localparam int SumW       = ((TOKEN_BITS > AmountW) ? TOKEN_BITS : AmountW) + 1;
  localparam int TransIds   = 2**TransIdW;

  // latched request
  action_e             act_q;
  logic [SlotW-1:0]    slot_q;
  logic [PlaceIdW-1:0] place_q;
  logic [TransIdW-1:0] trans_q;
  logic [AmountW-1:0]  amount_q;

  // step state
  logic [IdxW-1:0]      idx_q, nidx;
  logic [TransUseW-1:0] t_q;
  logic [TransIds-1:0]  en_q;
  arc_t                 cur_q, arc_rd;
  logic                 rok_q, pv_q;
  logic [PlaceDepth-1:0] valid_q;

  // results
  logic                res_fired_q, out_fired_q, out_valid_q;
  logic [TransIdW-1:0] res_trans_q, out_trans_q;
  logic [AmountW-1:0]  res_tok_q, out_tok_q;

  logic [LimW-1:0] plim, alim, nt_lim;
  logic [$bits(arc_t)-1:0] in_rdata, out_rdata;
  logic            arc_re, in_re, out_re, slot_ok, match;
  logic [AaW-1:0]  arc_raddr;
  logic            p_we, p_re;
  logic [PaW-1:0]  p_waddr, p_raddr;
  logic [PlaceIdW-1:0] p_rplace;
  logic [TOKEN_BITS-1:0] p_wdata, p_rdata, tok_eff;
  logic [SumW-1:0] tok_ext, w_ext, a_ext, tmax_ext, sub_v, add_v, add_sat, mark_sat;

  function automatic logic place_ok(input logic [PlaceIdW-1:0] p, input logic [LimW-1:0] lim);
    return LimW'(p) < lim;
  endfunction

  // limits of this net
  assign plim = (LimW'(cfg_i.places) > LimW'(PLACE_COUNT_MAX)) ?
                LimW'(PLACE_COUNT_MAX) : LimW'(cfg_i.places);
  always_comb begin
    if (cmd_i.pass == PASS_ADD) begin
      alim = LimW'(cfg_i.out_arcs);
    end else begin
      alim = LimW'(cfg_i.in_arcs);
    end
    if (alim > LimW'(ArcDepth)) begin
      alim = LimW'(ArcDepth);
    end
  end
  assign nt_lim = (LimW'(cfg_i.transitions) > LimW'(TransCountMax)) ?
                  LimW'(TransCountMax) : LimW'(cfg_i.transitions);

  assign sts_o.action     = act_q;
  assign sts_o.pass_empty = (alim == '0);
  assign sts_o.arc_last   = (LimW'(idx_q) + LimW'(1)) >= alim;
  assign sts_o.scan_end   = LimW'(t_q) >= nt_lim;
  assign sts_o.scan_hit   = (LimW'(t_q) >= LimW'(TransIds)) ? 1'b1 : en_q[t_q[TransIdW-1:0]];
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // arc tables
  assign slot_ok   = LimW'(slot_q) < LimW'(ARC_COUNT_MAX);
  assign nidx      = idx_q + IdxW'(1);
  assign arc_raddr = cmd_i.arc_prime ? '0 : nidx[AaW-1:0];
  assign arc_re    = cmd_i.arc_prime || (cmd_i.arc_fetch && !sts_o.arc_last);
  assign in_re     = arc_re && (cmd_i.pass != PASS_ADD);
  assign out_re    = arc_re && (cmd_i.pass == PASS_ADD);
  assign arc_rd    = arc_t'((cmd_i.pass == PASS_ADD) ? out_rdata : in_rdata);

  pnfe_ram #(
    .WIDTH  ($bits(arc_t)),
    .DEPTH  (ArcDepth),
    .ADDR_W (AaW)
  ) u_in_arcs (
    .clk_i   (clk_i),
    .we_i    (cmd_i.arc_in_wr && slot_ok),
    .waddr_i (slot_q[AaW-1:0]),
    .wdata_i ({place_q, trans_q, amount_q}),
    .re_i    (in_re),
    .raddr_i (arc_raddr),
    .rdata_o (in_rdata)
  );

  pnfe_ram #(
    .WIDTH  ($bits(arc_t)),
    .DEPTH  (ArcDepth),
    .ADDR_W (AaW)
  ) u_out_arcs (
    .clk_i   (clk_i),
    .we_i    (cmd_i.arc_out_wr && slot_ok),
    .waddr_i (slot_q[AaW-1:0]),
    .wdata_i ({place_q, trans_q, amount_q}),
    .re_i    (out_re),
    .raddr_i (arc_raddr),
    .rdata_o (out_rdata)
  );

  // marking store, unwritten entries read as zero through valid bits
  assign p_rplace = cmd_i.place_rd ? place_q : arc_rd.place;
  assign p_raddr  = p_rplace[PaW-1:0];
  assign p_re     = cmd_i.place_rd || cmd_i.arc_fetch;
  assign tok_eff  = (rok_q && pv_q) ? p_rdata : '0;

  assign tok_ext  = SumW'(tok_eff);
  assign w_ext    = SumW'(cur_q.weight);
  assign a_ext    = SumW'(amount_q);
  assign tmax_ext = SumW'({TOKEN_BITS{1'b1}});
  assign sub_v    = (tok_ext > w_ext) ? (tok_ext - w_ext) : '0;
  assign add_v    = tok_ext + w_ext;
  assign add_sat  = (add_v > tmax_ext) ? tmax_ext : add_v;
  assign mark_sat = (a_ext > tmax_ext) ? tmax_ext : a_ext;
  assign match    = (TransUseW'(cur_q.transition) == t_q);

  always_comb begin
    p_we    = 1'b0;
    p_waddr = cur_q.place[PaW-1:0];
    p_wdata = TOKEN_BITS'(add_sat);
    if (cmd_i.mark_wr) begin
      p_we    = place_ok(place_q, plim);
      p_waddr = place_q[PaW-1:0];
      p_wdata = TOKEN_BITS'(mark_sat);
    end else if (cmd_i.arc_exec && cmd_i.pass != PASS_EN) begin
      p_we = rok_q && match;
      if (cmd_i.pass == PASS_SUB) begin
        p_wdata = TOKEN_BITS'(sub_v);
      end
    end
  end

  pnfe_ram #(
    .WIDTH  (TOKEN_BITS),
    .DEPTH  (PlaceDepth),
    .ADDR_W (PaW)
  ) u_marking (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      idx_q       <= '0;
      t_q         <= '0;
      en_q        <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (p_we) begin
        valid_q[p_waddr] <= 1'b1;
      end
      if (cmd_i.arc_prime) begin
        idx_q <= '0;
      end else if (cmd_i.arc_exec) begin
        idx_q <= nidx;
      end
      if (cmd_i.step_init) begin
        t_q  <= '0;
        en_q <= '1;
      end else if (cmd_i.scan_next) begin
        t_q <= t_q + TransUseW'(1);
      end
      if (cmd_i.arc_exec && cmd_i.pass == PASS_EN && rok_q && tok_ext < w_ext) begin
        en_q[cur_q.transition] <= 1'b0;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q       <= action_e'(action_i);
      slot_q      <= slot_i;
      place_q     <= place_id_i;
      trans_q     <= transition_id_i;
      amount_q    <= amount_i;
      res_fired_q <= 1'b0;
      res_trans_q <= '0;
      res_tok_q   <= '0;
    end
    if (cmd_i.arc_fetch) begin
      cur_q <= arc_rd;
    end
    if (p_re) begin
      rok_q <= place_ok(p_rplace, plim);
      pv_q  <= valid_q[p_raddr];
    end
    if (cmd_i.tok_cap) begin
      res_tok_q <= AmountW'(tok_ext);
    end
    if (cmd_i.fire_hit) begin
      res_fired_q <= 1'b1;
      res_trans_q <= t_q[TransIdW-1:0];
    end
    if (cmd_i.res_load) begin
      out_fired_q <= res_fired_q;
      out_trans_q <= res_trans_q;
      out_tok_q   <= res_tok_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign fired_o            = out_fired_q;
  assign fired_transition_o = out_trans_q;
  assign token_count_o      = out_tok_q;

endmodule

// File: sv/petri_net_firing_engine.sv
`timescale 1ns / 1ps
// weighted petri net engine: each request writes a place marking or an arc table entry,
// reads a marking, or runs one step, and returns exactly one result. a step makes one
// pass over the input arc table to find which transitions are blocked, then scans
// transitions one per cycle for the lowest enabled one. if one fires, it makes a pass
// over the input arcs to take tokens and a pass over the output arcs to add them. each
// arc takes an arc memory read, then a marking memory read-modify-write. a stalled
// output holds a finished request until the previous result is taken. markings live
// in a small memory with one valid bit per place, so reset needs no clearing pass; arc
// entries are undefined until written. the next request is taken while the last result
// still waits at the output.
module petri_net_firing_engine
  import pnfe_pkg::*;
#(
  parameter int PLACE_COUNT_MAX = PlaceCountMaxDef,
  parameter int ARC_COUNT_MAX   = ArcCountMaxDef,
  parameter int TOKEN_BITS      = TokenBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ActionW-1:0]  action_i,
  input  logic [SlotW-1:0]    slot_i,
  input  logic [PlaceIdW-1:0] place_id_i,
  input  logic [TransIdW-1:0] transition_id_i,
  input  logic [AmountW-1:0]  amount_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                fired_o,
  output logic [TransIdW-1:0] fired_transition_o,
  output logic [AmountW-1:0]  token_count_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // no wait states on the register port
  assign pready = 1'b1;

  // register block: place, transition and arc counts
  pnfe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // sequencer for decode, arc passes and transition scan
  pnfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arc tables, marking store, enable vector and result register
  pnfe_dp #(
    .PLACE_COUNT_MAX (PLACE_COUNT_MAX),
    .ARC_COUNT_MAX   (ARC_COUNT_MAX),
    .TOKEN_BITS      (TOKEN_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .action_i           (action_i),
    .slot_i             (slot_i),
    .place_id_i         (place_id_i),
    .transition_id_i    (transition_id_i),
    .amount_i           (amount_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .fired_o            (fired_o),
    .fired_transition_o (fired_transition_o),
    .token_count_o      (token_count_o)
  );

endmodule

// File: tb/sv/petri_net_firing_engine_tb.sv
`timescale 1ns / 1ps
module petri_net_firing_engine_tb
  import pnfe_pkg::*;
();

  localparam int PlacesMax = PlaceCountMaxDef;
  localparam int ArcsMax   = ArcCountMaxDef;
  localparam int TransMax  = TransCountMax;
  localparam logic [AmountW-1:0] TokenTop = '1;

  // many times the longest quiet stretch, which comes from a full-size step
  localparam int QuietLimit = 5000;
  localparam int TailCycles = 40;
  localparam int IdlePct    = 29;
  localparam int NumPhases  = 14;
  // phase that runs with neither side ever idling
  localparam int CalmPhase  = 6;

  // action codes outside the defined set, the block must treat them as no-ops
  localparam logic [ActionW-1:0] ActJunkLo = 3'd5;
  localparam logic [ActionW-1:0] ActJunkHi = 3'd7;

  typedef struct packed {
    logic [ActionW-1:0]  action;
    logic [SlotW-1:0]    slot;
    logic [PlaceIdW-1:0] place;
    logic [TransIdW-1:0] trans;
    logic [AmountW-1:0]  amount;
  } request_t;

  typedef struct packed {
    logic                fired;
    logic [TransIdW-1:0] fired_t;
    logic [AmountW-1:0]  tokens;
  } reply_t;

  typedef struct packed {
    request_t req;
    logic     pinned;
    reply_t   reply;
  } dir_row_t;

  localparam logic   Pinned    = 1'b1;
  localparam logic   Predicted = 1'b0;
  localparam reply_t NoReply   = '0;
  localparam reply_t FullPlace = '{1'b0, 4'd0, 16'hFFFF};

  // rows before NetRowsStart run with the reset settings (nothing in the net),
  // the rest with 16 places, 3 transitions, 4 input arcs and 3 output arcs
  localparam int NetRowsStart = 6;
  localparam int NumDirRows   = 26;
  localparam dir_row_t DirRows [NumDirRows] = '{
    // empty net right after reset
    '{'{ACT_RD_MARK,    6'd0,  4'd0,  4'd0,  16'd0},      Pinned,    NoReply},
    '{'{ACT_WR_MARK,    6'd0,  4'd3,  4'd0,  16'hFFFF},   Pinned,    NoReply},
    '{'{ACT_RD_MARK,    6'd0,  4'd3,  4'd0,  16'd0},      Pinned,    NoReply},
    '{'{ACT_STEP,       6'd0,  4'd0,  4'd0,  16'd0},      Pinned,    NoReply},
    '{'{ActJunkLo,      6'd0,  4'd0,  4'd0,  16'd0},      Pinned,    NoReply},
    '{'{ActJunkHi,      6'h3F, 4'hF,  4'hF,  16'hFFFF},   Pinned,    NoReply},
    // t0 takes two tokens twice from place 0, t1 needs a full place 15
    '{'{ACT_WR_IN_ARC,  6'd0,  4'd0,  4'd0,  16'd2},      Pinned,    NoReply},
    '{'{ACT_WR_IN_ARC,  6'd1,  4'd0,  4'd0,  16'd2},      Pinned,    NoReply},
    '{'{ACT_WR_IN_ARC,  6'd2,  4'd15, 4'd1,  16'hFFFF},   Pinned,    NoReply},
    '{'{ACT_WR_IN_ARC,  6'd3,  4'd1,  4'd2,  16'd1},      Pinned,    NoReply},
    '{'{ACT_WR_IN_ARC,  6'd63, 4'd15, 4'd15, 16'd0},      Pinned,    NoReply},
    '{'{ACT_WR_OUT_ARC, 6'd0,  4'd2,  4'd0,  16'hFFFF},   Pinned,    NoReply},
    '{'{ACT_WR_OUT_ARC, 6'd1,  4'd15, 4'd1,  16'd5},      Pinned,    NoReply},
    '{'{ACT_WR_OUT_ARC, 6'd2,  4'd1,  4'd2,  16'd3},      Pinned,    NoReply},
    '{'{ACT_WR_MARK,    6'd0,  4'd0,  4'd0,  16'd3},      Pinned,    NoReply},
    '{'{ACT_WR_MARK,    6'd0,  4'd2,  4'd0,  16'd10},     Pinned,    NoReply},
    '{'{ACT_WR_MARK,    6'd0,  4'd15, 4'd0,  16'hFFFF},   Pinned,    NoReply},
    '{'{ACT_RD_MARK,    6'd0,  4'd15, 4'd0,  16'd0},      Pinned,    FullPlace},
    // repeated arc drives place 0 through zero, output arc saturates place 2
    '{'{ACT_STEP,       6'd0,  4'd0,  4'd0,  16'd0},      Predicted, NoReply},
    '{'{ACT_RD_MARK,    6'd0,  4'd0,  4'd0,  16'd0},      Predicted, NoReply},
    '{'{ACT_RD_MARK,    6'd0,  4'd2,  4'd0,  16'd0},      Pinned,    FullPlace},
    '{'{ACT_STEP,       6'd0,  4'd0,  4'd0,  16'd0},      Predicted, NoReply},
    // nothing enabled now
    '{'{ACT_STEP,       6'd0,  4'd0,  4'd0,  16'd0},      Predicted, NoReply},
    '{'{ACT_WR_MARK,    6'd0,  4'd1,  4'd0,  16'd1},      Pinned,    NoReply},
    '{'{ACT_STEP,       6'd0,  4'd0,  4'd0,  16'd0},      Predicted, NoReply},
    '{'{ACT_RD_MARK,    6'd0,  4'd1,  4'd0,  16'd0},      Predicted, NoReply}
  };

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                in_valid_i         = 1'b0;
  logic                in_ready_o;
  logic [ActionW-1:0]  action_i           = '0;
  logic [SlotW-1:0]    slot_i             = '0;
  logic [PlaceIdW-1:0] place_id_i         = '0;
  logic [TransIdW-1:0] transition_id_i    = '0;
  logic [AmountW-1:0]  amount_i           = '0;
  logic                out_valid_o;
  logic                out_ready_i        = 1'b0;
  logic                fired_o;
  logic [TransIdW-1:0] fired_transition_o;
  logic [AmountW-1:0]  token_count_o;
  logic                psel               = 1'b0;
  logic                penable            = 1'b0;
  logic                pwrite             = 1'b0;
  logic [ApbAddrW-1:0] paddr              = '0;
  logic [ApbDataW-1:0] pwdata             = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  petri_net_firing_engine dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .slot_i            (slot_i),
    .place_id_i        (place_id_i),
    .transition_id_i   (transition_id_i),
    .amount_i          (amount_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .fired_o           (fired_o),
    .fired_transition_o(fired_transition_o),
    .token_count_o     (token_count_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #4 clk_i = ~clk_i;

  // shadow copy of the net: marking, both arc tables and the four settings
  logic [AmountW-1:0] marking [PlacesMax];
  arc_t               in_arcs [ArcsMax];
  arc_t               out_arcs [ArcsMax];
  cfg_t               net_cfg;

  // replies owed by the block, oldest first
  reply_t replies_due [$];

  bit calm_mode;
  int mismatches;
  int items_sent;
  int results_seen;
  int fires_predicted;
  int quiet_cycles;

  function automatic int clamp(int v, int lim);
    return v > lim ? lim : v;
  endfunction

  // places at or above the places setting do not exist
  function automatic bit place_present(logic [PlaceIdW-1:0] p);
    return int'(p) < clamp(int'(net_cfg.places), PlacesMax);
  endfunction

  // every input arc of t that names a live place must find its weight in tokens
  function automatic bit trans_enabled(int t);
    int   n;
    arc_t a;
    n = clamp(int'(net_cfg.in_arcs), ArcsMax);
    for (int i = 0; i < n; i++) begin
      a = in_arcs[i];
      if (int'(a.transition) == t && place_present(a.place) && marking[a.place] < a.weight)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // take input weights arc by arc (floor at zero), then add output weights (ceiling)
  function automatic void fire_transition(int t);
    int               n;
    arc_t             a;
    logic [AmountW:0] sum;
    n = clamp(int'(net_cfg.in_arcs), ArcsMax);
    for (int i = 0; i < n; i++) begin
      a = in_arcs[i];
      if (int'(a.transition) == t && place_present(a.place))
        marking[a.place] = marking[a.place] > a.weight ? marking[a.place] - a.weight : '0;
    end
    n = clamp(int'(net_cfg.out_arcs), ArcsMax);
    for (int i = 0; i < n; i++) begin
      a = out_arcs[i];
      if (int'(a.transition) == t && place_present(a.place)) begin
        sum = {1'b0, marking[a.place]} + {1'b0, a.weight};
        marking[a.place] = sum[AmountW] ? TokenTop : sum[AmountW-1:0];
      end
    end
  endfunction

  // applies one request to the shadow net and returns the reply it must produce
  function automatic reply_t apply_to_net(request_t r);
    reply_t rep;
    int     n_t;
    rep = '0;
    case (r.action)
      ACT_WR_MARK: begin
        if (place_present(r.place)) marking[r.place] = r.amount;
      end
      ACT_WR_IN_ARC:  in_arcs[r.slot] = '{r.place, r.trans, r.amount};
      ACT_WR_OUT_ARC: out_arcs[r.slot] = '{r.place, r.trans, r.amount};
      ACT_STEP: begin
        // lowest-numbered enabled transition wins
        n_t = clamp(int'(net_cfg.transitions), TransMax);
        for (int t = 0; t < n_t && !rep.fired; t++) begin
          if (trans_enabled(t)) begin
            fire_transition(t);
            rep.fired   = 1'b1;
            rep.fired_t = TransIdW'(t);
          end
        end
      end
      ACT_RD_MARK: begin
        if (place_present(r.place)) rep.tokens = marking[r.place];
      end
      default: ;
    endcase
    return rep;
  endfunction

  // mostly a value below n, now and then anything up to any_max
  function automatic int below_or_any(int n, int any_max);
    if (n > 0 && $urandom_range(9) != 0) return int'($urandom_range(n - 1));
    return int'($urandom_range(any_max));
  endfunction

  // small counts so transitions fire often, with a full place or a wild value now and then
  function automatic logic [AmountW-1:0] token_amount();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return TokenTop;
    if (pick == 1) return AmountW'($urandom);
    return AmountW'($urandom_range(8));
  endfunction

  function automatic request_t arc_request(logic [ActionW-1:0] act, int slot);
    request_t r;
    r.action = act;
    r.slot   = SlotW'(slot);
    r.place  = PlaceIdW'(below_or_any(clamp(int'(net_cfg.places), PlacesMax), 15));
    r.trans  = TransIdW'(below_or_any(clamp(int'(net_cfg.transitions), TransMax), 15));
    r.amount = token_amount();
    return r;
  endfunction

  // request mix: mostly steps and reads over a well-formed net, some edits and noise
  function automatic request_t random_request();
    request_t r;
    int       roll;
    roll = $urandom_range(99);
    if (roll < 62) begin
      r.action = roll < 35 ? ACT_STEP : (roll < 50 ? ACT_RD_MARK : ACT_WR_MARK);
      r.slot   = SlotW'($urandom);
      r.place  = PlaceIdW'(below_or_any(clamp(int'(net_cfg.places), PlacesMax), 15));
      r.trans  = TransIdW'($urandom);
      r.amount = token_amount();
    end else if (roll < 74) begin
      r = arc_request(ACT_WR_IN_ARC, below_or_any(clamp(int'(net_cfg.in_arcs), ArcsMax), 63));
    end else if (roll < 86) begin
      r = arc_request(ACT_WR_OUT_ARC, below_or_any(clamp(int'(net_cfg.out_arcs), ArcsMax), 63));
    end else begin
      // any action code, unknown ones included, with random fields
      r.action = ActionW'($urandom);
      r.slot   = SlotW'($urandom);
      r.place  = PlaceIdW'($urandom);
      r.trans  = TransIdW'($urandom);
      r.amount = AmountW'($urandom);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s at result %0d: got %0h, expected %0h",
             $time, what, results_seen, got, want);
    mismatches++;
  endtask

  // holds valid until accepted; valid only drops when a gap is taken
  task automatic send_request(request_t r, logic pinned, reply_t pinned_reply);
    reply_t want;
    if (!calm_mode) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    action_i        <= r.action;
    slot_i          <= r.slot;
    place_id_i      <= r.place;
    transition_id_i <= r.trans;
    amount_i        <= r.amount;
    do @(posedge clk_i); while (!in_ready_o);
    want = apply_to_net(r);
    if (want.fired) fires_predicted++;
    replies_due.push_back(pinned ? pinned_reply : want);
    items_sent++;
  endtask

  // every request gives a reply, so no replies due means the block is idle
  task automatic wait_net_quiet();
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(reg_e idx, logic [ApbDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PLACES:   net_cfg.places      = value[PlacesW-1:0];
      REG_TRANS:    net_cfg.transitions = value[TransUseW-1:0];
      REG_IN_ARCS:  net_cfg.in_arcs     = value[ArcsW-1:0];
      REG_OUT_ARCS: net_cfg.out_arcs    = value[ArcsW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_net_config(int pl, int tr, int ia, int oa);
    write_register(REG_PLACES, ApbDataW'(pl));
    write_register(REG_TRANS, ApbDataW'(tr));
    write_register(REG_IN_ARCS, ApbDataW'(ia));
    write_register(REG_OUT_ARCS, ApbDataW'(oa));
  endtask

  // rewrite the arc slots in use, input table first
  task automatic load_arcs(int n_in, int n_out);
    for (int s = 0; s < n_in + n_out; s++) begin
      if (s < n_in) send_request(arc_request(ACT_WR_IN_ARC, s), Predicted, NoReply);
      else send_request(arc_request(ACT_WR_OUT_ARC, s - n_in), Predicted, NoReply);
    end
  endtask

  // receiver side stalls at random except in the calm phase
  always @(posedge clk_i) begin
    out_ready_i <= calm_mode || ($urandom_range(99) >= IdlePct);
  end

  // in-order reply check
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unrequested result",
                        32'({fired_o, fired_transition_o, token_count_o}), 32'd0);
      end else begin
        want = replies_due.pop_front();
        if (fired_o !== want.fired) report_mismatch("fired", 32'(fired_o), 32'(want.fired));
        if (fired_transition_o !== want.fired_t)
          report_mismatch("fired_transition", 32'(fired_transition_o), 32'(want.fired_t));
        if (token_count_o !== want.tokens)
          report_mismatch("token_count", 32'(token_count_o), 32'(want.tokens));
      end
      results_seen++;
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int pl;
    int tr;
    int ia;
    int oa;
    int n_items;
    net_cfg = '0;
    for (int p = 0; p < PlacesMax; p++) marking[p] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, the small hand-built net starts at NetRowsStart
    for (int i = 0; i < NumDirRows; i++) begin
      if (i == NetRowsStart) begin
        wait_net_quiet();
        set_net_config(16, 3, 4, 3);
      end
      send_request(DirRows[i].req, DirRows[i].pinned, DirRows[i].reply);
    end

    // random phases, each with its own settings written while the block is idle
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin pl = 16; tr = 16; ia = 16;  oa = 16;  n_items = 100; end
        1: begin pl = 16; tr = 16; ia = 64;  oa = 64;  n_items = 50;  end
        // register extremes, all clamp to the block's limits
        2: begin pl = 31; tr = 31; ia = 127; oa = 127; n_items = 50;  end
        3: begin pl = 0;  tr = 0;  ia = 0;   oa = 0;   n_items = 40;  end
        default: begin
          // mostly small nets to keep steps short, now and then any register value
          pl = $urandom_range(7) == 0 ? $urandom_range(31) : $urandom_range(1, 16);
          tr = $urandom_range(7) == 0 ? $urandom_range(31) : $urandom_range(1, 16);
          ia = $urandom_range(7) == 0 ? $urandom_range(127) : $urandom_range(16);
          oa = $urandom_range(7) == 0 ? $urandom_range(127) : $urandom_range(16);
          n_items = 120;
        end
      endcase
      wait_net_quiet();
      set_net_config(pl, tr, ia, oa);
      calm_mode = (phase == CalmPhase);
      // the first phase fills both tables so no later step reads an unwritten slot
      if (phase == 0) load_arcs(ArcsMax, ArcsMax);
      else if ($urandom_range(2) == 0) load_arcs(clamp(ia, ArcsMax), clamp(oa, ArcsMax));
      repeat (n_items) send_request(random_request(), Predicted, NoReply);
    end

    wait_net_quiet();
    calm_mode = 1'b0;
    repeat (TailCycles) @(posedge clk_i);

    $display("ran %0d requests over %0d net settings, %0d results checked",
             items_sent, NumPhases + 2, results_seen);
    $display("%0d steps fired a transition, %0d mismatches", fires_predicted, mismatches);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
